FILE: src/cfd_pkg.sv
// Shared types, constants and the CRC byte update of the channel frame decoder.
package cfd_pkg;

  localparam int MAX_ANALOG_CH_DEF  = 16;
  localparam int MAX_DIGITAL_CH_DEF = 64;

  localparam int HDR_LEN = 7;
  localparam logic [7:0] LEN_MAX  = 8'd255;
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_START_BYTE  = 2'd0;
  localparam logic [1:0] REG_MIN_LENGTH  = 2'd1;
  localparam logic [1:0] REG_MAX_ANALOG  = 2'd2;
  localparam logic [1:0] REG_MAX_DIGITAL = 2'd3;

  localparam logic [7:0] START_BYTE_RST  = 8'd0;
  localparam logic [7:0] MIN_LENGTH_RST  = 8'd8;
  localparam logic [4:0] MAX_ANALOG_RST  = 5'd16;
  localparam logic [6:0] MAX_DIGITAL_RST = 7'd64;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_OVERSIZE  = 3'd3;
  localparam logic [2:0] ST_ANALOG    = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;
  localparam logic [2:0] ST_CRC       = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_DIGITAL = 2'd1;
  localparam logic [1:0] KIND_ANALOG  = 2'd2;

  // Selects which result the output register loads.
  localparam logic [1:0] SEL_STATUS  = 2'd0;
  localparam logic [1:0] SEL_DIGITAL = 2'd1;
  localparam logic [1:0] SEL_ANALOG  = 2'd2;
  localparam logic [1:0] SEL_HEADER  = 2'd3;

  typedef struct packed {
    logic       accept;   // input byte taken this cycle
    logic       idx_clr;  // restart the emit counter
    logic       idx_inc;  // advance the emit counter
    logic       load;     // load the output register
    logic [1:0] sel;      // which result to load
    logic       clear;    // drop the per-buffer state
  } cfd_cmd_t;

  typedef struct packed {
    logic fail;       // frame check failed
    logic dig_more;   // another digital result remains
    logic ana_more;   // another analog result remains
    logic out_free;   // output register can take a result
  } cfd_stat_t;

  // Reflected CRC-8 update over one byte, least significant bit first.
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    logic       mix;
    c = crc;
    d = b;
    for (int k = 0; k < 8; k++) begin
      mix = c[0] ^ d[0];
      c = c >> 1;
      if (mix) begin
        c = c ^ CRC_POLY;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

FILE: src/cfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/cfd_datapath.sv
// Datapath: configuration, header, CRC, payload stores, checks and output register.
module cfd_datapath #(
  parameter int MAX_ANALOG_CH  = cfd_pkg::MAX_ANALOG_CH_DEF,
  parameter int MAX_DIGITAL_CH = cfd_pkg::MAX_DIGITAL_CH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [7:0]        in_byte,
  input  cfd_pkg::cfd_cmd_t cmd,
  output cfd_pkg::cfd_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [71:0]       out_data,
  output logic [1:0]        out_kind,
  output logic              out_last
);

  localparam int DIG_BYTES = (MAX_DIGITAL_CH + 7) / 8;
  localparam int DAW = (DIG_BYTES > 1) ? $clog2(DIG_BYTES) : 1;
  localparam int AAW = (MAX_ANALOG_CH > 1) ? $clog2(MAX_ANALOG_CH) : 1;
  localparam logic [8:0] DIG_BYTES_W = 9'(DIG_BYTES);
  localparam logic [7:0] ANA_CH_W    = 8'(MAX_ANALOG_CH);
  localparam logic [7:0] DIG_CH_W    = 8'(MAX_DIGITAL_CH);

  logic [7:0] start_byte, min_length;
  logic [4:0] max_analog;
  logic [6:0] max_digital;

  logic [7:0] byte_counter, crc_acc, received_crc, low_byte_hold;
  logic [7:0] hdr [cfd_pkg::HDR_LEN];
  logic [cfd_pkg::HDR_LEN-1:0] hdr_vld;
  logic [7:0] idx;

  logic [7:0] h0, h1, h2, h3, h4, na, nd;
  logic [9:0] expected;
  logic [7:0] acap, dlim;
  logic [2:0] st;
  logic [10:0] bitpos, bits;
  logic [7:0] dmask;
  logic [7:0] dcount;

  logic [7:0] off;
  logic [7:0] ana_slot;
  logic [7:0] dig_slot;
  logic       dig_we, ana_we;
  logic [7:0] dig_rdata;
  logic [15:0] ana_rdata;

  assign h0 = hdr_vld[0] ? hdr[0] : 8'd0;
  assign h1 = hdr_vld[1] ? hdr[1] : 8'd0;
  assign h2 = hdr_vld[2] ? hdr[2] : 8'd0;
  assign h3 = hdr_vld[3] ? hdr[3] : 8'd0;
  assign h4 = hdr_vld[4] ? hdr[4] : 8'd0;
  assign na = hdr_vld[5] ? hdr[5] : 8'd0;
  assign nd = hdr_vld[6] ? hdr[6] : 8'd0;

  assign expected = 10'd8 + {2'd0, nd} + {1'b0, na, 1'b0};
  assign acap = ({3'd0, max_analog} < ANA_CH_W) ? {3'd0, max_analog} : ANA_CH_W;
  assign dlim = ({1'b0, max_digital} < DIG_CH_W) ? {1'b0, max_digital} : DIG_CH_W;

  // Frame checks in priority order.
  always_comb begin
    if (byte_counter < min_length) begin
      st = cfd_pkg::ST_SHORT;
    end else if (h0 != start_byte) begin
      st = cfd_pkg::ST_BAD_START;
    end else if (expected > 10'd255) begin
      st = cfd_pkg::ST_OVERSIZE;
    end else if (na > acap) begin
      st = cfd_pkg::ST_ANALOG;
    end else if ({2'd0, byte_counter} < expected) begin
      st = cfd_pkg::ST_TRUNC;
    end else if (crc_acc != received_crc) begin
      st = cfd_pkg::ST_CRC;
    end else begin
      st = cfd_pkg::ST_OK;
    end
  end

  assign bitpos = {idx, 3'd0};
  assign bits   = {3'd0, dlim} - bitpos;
  assign dmask  = (bits < 11'd8) ? ~(8'hFF << bits[2:0]) : 8'hFF;
  assign dcount = ({nd[4:0], 3'd0} > dlim) ? dlim : {nd[4:0], 3'd0};

  assign stat.fail     = (st != cfd_pkg::ST_OK);
  assign stat.dig_more = (idx < nd) && (bitpos < {3'd0, dlim});
  assign stat.ana_more = (idx < na);
  assign stat.out_free = !out_valid || out_ready;

  // Placement of a payload byte within the frame.
  assign off      = byte_counter - 8'd7 - nd;
  assign dig_slot = byte_counter - 8'd7;
  assign ana_slot = {1'b0, off[7:1]};

  always_comb begin
    dig_we = 1'b0;
    ana_we = 1'b0;
    if (cmd.accept && byte_counter < cfd_pkg::LEN_MAX && byte_counter >= 8'd7
        && ({1'b0, byte_counter} + 9'd1) < expected[8:0] && expected[9] == 1'b0) begin
      if ({1'b0, byte_counter} < 9'd7 + {1'b0, nd}) begin
        dig_we = ({1'b0, dig_slot} < DIG_BYTES_W);
      end else begin
        ana_we = off[0] && (ana_slot < ANA_CH_W);
      end
    end
  end

  cfd_ram #(.WIDTH(8), .DEPTH(DIG_BYTES)) u_dig_ram (
    .clk   (clk),
    .we    (dig_we),
    .waddr (dig_slot[DAW-1:0]),
    .wdata (in_byte),
    .raddr (idx[DAW-1:0]),
    .rdata (dig_rdata)
  );

  cfd_ram #(.WIDTH(16), .DEPTH(MAX_ANALOG_CH)) u_ana_ram (
    .clk   (clk),
    .we    (ana_we),
    .waddr (ana_slot[AAW-1:0]),
    .wdata ({in_byte, low_byte_hold}),
    .raddr (idx[AAW-1:0]),
    .rdata (ana_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte  <= cfd_pkg::START_BYTE_RST;
      min_length  <= cfd_pkg::MIN_LENGTH_RST;
      max_analog  <= cfd_pkg::MAX_ANALOG_RST;
      max_digital <= cfd_pkg::MAX_DIGITAL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cfd_pkg::REG_START_BYTE:  start_byte  <= cfg_data;
        cfd_pkg::REG_MIN_LENGTH:  min_length  <= cfg_data;
        cfd_pkg::REG_MAX_ANALOG:  max_analog  <= cfg_data[4:0];
        cfd_pkg::REG_MAX_DIGITAL: max_digital <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Per-buffer receive state.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      byte_counter  <= 8'd0;
      crc_acc       <= 8'd0;
      received_crc  <= 8'd0;
      low_byte_hold <= 8'd0;
      hdr_vld       <= '0;
    end else if (cmd.accept && byte_counter < cfd_pkg::LEN_MAX) begin
      byte_counter <= byte_counter + 8'd1;
      if (byte_counter < 8'd7) begin
        hdr[byte_counter[2:0]]     <= in_byte;
        hdr_vld[byte_counter[2:0]] <= 1'b1;
        crc_acc <= cfd_pkg::crc_step(crc_acc, in_byte);
      end else if ({2'd0, byte_counter} + 10'd1 < expected) begin
        crc_acc <= cfd_pkg::crc_step(crc_acc, in_byte);
        if (!({1'b0, byte_counter} < 9'd7 + {1'b0, nd}) && !off[0]) begin
          low_byte_hold <= in_byte;
        end
      end else if ({2'd0, byte_counter} + 10'd1 == expected) begin
        received_crc <= in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.idx_clr) begin
      idx <= 8'd0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 8'd1;
    end
  end

  // Output register; tdata fields from bit 0: status, index, value, env_id,
  // sequence_res, run_level, flag_bits, analog_count, digital_count.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= '0;
      out_last <= 1'b0;
      case (cmd.sel)
        cfd_pkg::SEL_STATUS: begin
          out_kind      <= cfd_pkg::KIND_HEADER;
          out_data[2:0] <= st;
          out_last      <= 1'b1;
        end
        cfd_pkg::SEL_DIGITAL: begin
          out_kind       <= cfd_pkg::KIND_DIGITAL;
          out_data[6:3]  <= idx[3:0];
          out_data[22:7] <= {8'd0, dig_rdata & dmask};
        end
        cfd_pkg::SEL_ANALOG: begin
          out_kind       <= cfd_pkg::KIND_ANALOG;
          out_data[6:3]  <= idx[3:0];
          out_data[22:7] <= ana_rdata;
        end
        default: begin
          out_kind        <= cfd_pkg::KIND_HEADER;
          out_data[30:23] <= h1;
          out_data[38:31] <= h2;
          out_data[46:39] <= h3;
          out_data[54:47] <= h4;
          out_data[59:55] <= na[4:0];
          out_data[66:60] <= dcount[6:0];
          out_last        <= 1'b1;
        end
      endcase
    end
  end

endmodule

FILE: src/cfd_controller.sv
// Controller: sequences byte reception, the frame check and the result burst.
module cfd_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  cfd_pkg::cfd_stat_t stat,
  output cfd_pkg::cfd_cmd_t  cmd
);

  localparam logic [2:0] S_RX    = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DRD   = 3'd2;
  localparam logic [2:0] S_DEMIT = 3'd3;
  localparam logic [2:0] S_ARD   = 3'd4;
  localparam logic [2:0] S_AEMIT = 3'd5;
  localparam logic [2:0] S_HDR   = 3'd6;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_RX);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = cfd_pkg::SEL_STATUS;
    case (state)
      S_RX: begin
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.fail) begin
          if (stat.out_free) begin
            cmd.load   = 1'b1;
            cmd.clear  = 1'b1;
            state_next = S_RX;
          end
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = S_DRD;
        end
      end
      S_DRD: begin
        if (stat.dig_more) begin
          state_next = S_DEMIT;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = S_ARD;
        end
      end
      S_DEMIT: begin
        cmd.sel = cfd_pkg::SEL_DIGITAL;
        if (stat.out_free) begin
          cmd.load    = 1'b1;
          cmd.idx_inc = 1'b1;
          state_next  = S_DRD;
        end
      end
      S_ARD: begin
        state_next = stat.ana_more ? S_AEMIT : S_HDR;
      end
      S_AEMIT: begin
        cmd.sel = cfd_pkg::SEL_ANALOG;
        if (stat.out_free) begin
          cmd.load    = 1'b1;
          cmd.idx_inc = 1'b1;
          state_next  = S_ARD;
        end
      end
      S_HDR: begin
        cmd.sel = cfd_pkg::SEL_HEADER;
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.clear  = 1'b1;
          state_next = S_RX;
        end
      end
      default: state_next = S_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RX;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/channel_frame_decoder_top.sv
// Top level of the channel frame decoder.
//
// The slave stream carries one received buffer byte per transaction in
// s_axis_tdata, with s_axis_tlast high on the final byte of the buffer.
// Each accepted byte updates the byte count, the running reflected CRC-8
// (polynomial 0x8C) and the header or payload stores. After the final byte
// the frame is checked. A failed frame yields one status transaction; a
// good one yields the digital bytes, the analog words and then a header
// transaction; each payload word is read from a RAM with a registered read port.
// m_axis_tlast marks the last result of a buffer, m_axis_tuser its kind.
// While results are emitted s_axis_tready is low; it rises again once the
// last result sits in the output register, so the next buffer can start
// while that result still waits for the receiver. A stalled receiver
// holds the result burst in place; nothing is dropped.
// Config writes take effect at the next edge; the user makes them only while idle,
// not enforced by the block. Reset (rst, synchronous) restores register defaults and
// clears the buffer state and the output stream; the payload RAMs need no clearing.
module channel_frame_decoder_top #(
  parameter int MAX_ANALOG_CH  = cfd_pkg::MAX_ANALOG_CH_DEF,
  parameter int MAX_DIGITAL_CH = cfd_pkg::MAX_DIGITAL_CH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic        s_axis_tlast,   // end_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, index, value, env_id, sequence_res, run_level, flag_bits,
  // analog_count, digital_count, zero fill
  output logic [71:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last_result
);

  cfd_pkg::cfd_cmd_t  cmd;
  cfd_pkg::cfd_stat_t stat;

  cfd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cfd_datapath #(
    .MAX_ANALOG_CH  (MAX_ANALOG_CH),
    .MAX_DIGITAL_CH (MAX_DIGITAL_CH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (s_axis_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule
